// File: hdl/sle_pkg.sv
// sle_pkg: shared types and character constants of the serial line editor.
// No dependencies; compiled first.

package sle_pkg;

  // Received control characters and printable range bounds
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_KILL  = 8'h15;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_DEL   = 8'h7F;

  localparam logic [6:0] SPACE7   = 7'h20;

  // Longest delivered line, and erase count ceiling of the result field
  localparam logic [5:0] MAX_LIM    = 6'd62;
  localparam logic [5:0] ERASE_SAT  = 6'd63;
  localparam logic [5:0] LIM_RESET  = 6'd62;

  // Result kinds
  typedef enum logic [2:0] {
    KIND_ECHO  = 3'd0,
    KIND_BELL  = 3'd1,
    KIND_NL    = 3'd2,
    KIND_ERASE = 3'd3,
    KIND_CHAR  = 3'd4,
    KIND_END   = 3'd5
  } kind_e;

  // Commands passed from the front to the back
  typedef enum logic [2:0] {
    OP_PUT    = 3'd0,
    OP_BELL   = 3'd1,
    OP_ERASE1 = 3'd2,
    OP_KILL   = 3'd3,
    OP_LINE   = 3'd4
  } op_e;

endpackage

// File: hdl/sle_rx_if.sv
// sle_rx_if: valid/ready channel carrying one received byte per beat.
// No dependencies.

interface sle_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// File: hdl/sle_res_if.sv
// sle_res_if: valid/ready channel carrying one editor result per beat.
// No dependencies.

interface sle_res_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [6:0] out_char;
  logic [5:0] erase_count;
  logic       last;

  modport source (output valid, output kind, output out_char, output erase_count,
                  output last, input ready);
  modport sink   (input valid, input kind, input out_char, input erase_count,
                  input last, output ready);
endinterface

// File: hdl/sle_queue.sv
// sle_queue: two-entry command queue between the editor front and back.
// No package dependencies.

module sle_queue #(
  parameter int W = 24
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] push_data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic         valid_o,
  output logic [W-1:0] data_o
);

  logic [W-1:0] mem_q [2];
  logic         wr_ptr_q, wr_ptr_d;
  logic         rd_ptr_q, rd_ptr_d;
  logic [1:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("push into full command queue");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o) else $error("pop from empty command queue");

endmodule

// File: hdl/sle_front.sv
// sle_front: takes received bytes, tracks line length and length register;
// turns each byte into a command or drops it. Uses sle_pkg, sle_rx_if.

module sle_front #(
  parameter int BUFFER_DEPTH = 64,
  localparam int LW = $clog2(BUFFER_DEPTH)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  sle_rx_if.sink         rx,
  input  logic           cfg_we_i,
  input  logic [5:0]     cfg_wdata_i,
  input  logic           q_full_i,
  output logic           push_o,
  output sle_pkg::op_e   op_o,
  output logic [6:0]     chr_o,
  output logic [LW-1:0]  num_o,
  output logic [5:0]     cnt_o
);

  localparam int LINE_CAP = BUFFER_DEPTH - 2;
  localparam int CW       = (LW > 6) ? LW : 6;

  logic [LW-1:0] line_len_q, line_len_d;
  logic [5:0]    lim_q;
  logic [5:0]    lim;
  logic [CW-1:0] len_ext;
  logic [CW-1:0] deliver_len;
  logic          accept;
  logic          cmd_valid;
  logic [7:0]    b;

  assign rx.ready = ~q_full_i;
  assign accept   = rx.valid & ~q_full_i;
  assign push_o   = accept & cmd_valid;
  assign b        = rx.rx_byte;

  assign lim         = (lim_q > sle_pkg::MAX_LIM) ? sle_pkg::MAX_LIM : lim_q;
  assign len_ext     = CW'(line_len_q);
  assign deliver_len = (len_ext < CW'(lim)) ? len_ext : CW'(lim);

  always_comb begin
    cmd_valid  = 1'b1;
    op_o       = sle_pkg::OP_BELL;
    chr_o      = b[6:0];
    num_o      = line_len_q;
    cnt_o      = '0;
    line_len_d = line_len_q;
    priority if (b == sle_pkg::CH_NUL) begin
      cmd_valid = 1'b0;
    end else if (b >= sle_pkg::CH_SPACE && b <= sle_pkg::CH_TILDE) begin
      if (line_len_q < LW'(LINE_CAP)) begin
        op_o       = sle_pkg::OP_PUT;
        line_len_d = line_len_q + 1'b1;
      end
    end else if (b == sle_pkg::CH_BS || b == sle_pkg::CH_DEL) begin
      if (line_len_q != '0) begin
        op_o       = sle_pkg::OP_ERASE1;
        line_len_d = line_len_q - 1'b1;
      end else begin
        cmd_valid = 1'b0;
      end
    end else if (b == sle_pkg::CH_KILL) begin
      op_o       = sle_pkg::OP_KILL;
      cnt_o      = (len_ext > CW'(sle_pkg::ERASE_SAT)) ? sle_pkg::ERASE_SAT : len_ext[5:0];
      line_len_d = '0;
    end else if (b == sle_pkg::CH_CR || b == sle_pkg::CH_LF) begin
      op_o       = sle_pkg::OP_LINE;
      num_o      = LW'(deliver_len);
      line_len_d = '0;
    end else begin
      op_o = sle_pkg::OP_BELL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_len_q <= '0;
      lim_q      <= sle_pkg::LIM_RESET;
    end else begin
      if (push_o) begin
        line_len_q <= line_len_d;
      end
      if (cfg_we_i) begin
        lim_q <= cfg_wdata_i;
      end
    end
  end

  a_len_in_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_len_q <= LW'(LINE_CAP)) else $error("line length beyond capacity");

endmodule

// File: hdl/sle_back.sv
// sle_back: executes editor commands, owns the line store and the result
// register; trims trailing spaces and streams the line. Uses sle_pkg, sle_res_if.

module sle_back #(
  parameter int BUFFER_DEPTH = 64,
  localparam int LW = $clog2(BUFFER_DEPTH)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  input  sle_pkg::op_e  q_op_i,
  input  logic [6:0]    q_chr_i,
  input  logic [LW-1:0] q_num_i,
  input  logic [5:0]    q_cnt_i,
  output logic          pop_o,
  sle_res_if.source     res
);

  localparam int LINE_CAP = BUFFER_DEPTH - 2;
  localparam int AW       = (LINE_CAP > 1) ? $clog2(LINE_CAP) : 1;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SCAN = 6'b000010,
    S_SCHK = 6'b000100,
    S_EMIT = 6'b001000,
    S_ECHK = 6'b010000,
    S_END  = 6'b100000
  } state_e;

  state_e        state_q, state_d;
  logic [LW-1:0] idx_q, idx_d;
  logic [LW-1:0] pos_q, pos_d;
  logic [LW-1:0] len_q, len_d;

  logic [6:0]    store_q [LINE_CAP];
  logic [6:0]    rd_q;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;

  logic          out_v_q;
  sle_pkg::kind_e kind_q;
  logic [6:0]    char_q;
  logic [5:0]    cnt_q;
  logic          last_q;

  logic          can_load;
  logic          load;
  sle_pkg::kind_e ld_kind;
  logic [6:0]    ld_char;
  logic [5:0]    ld_cnt;
  logic          ld_last;

  assign can_load        = ~out_v_q | res.ready;
  assign res.valid       = out_v_q;
  assign res.kind        = kind_q;
  assign res.out_char    = char_q;
  assign res.erase_count = cnt_q;
  assign res.last        = last_q;
  assign wr_addr         = AW'(q_num_i);

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    pos_d   = pos_q;
    len_d   = len_q;
    pop_o   = 1'b0;
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    load    = 1'b0;
    ld_kind = sle_pkg::KIND_BELL;
    ld_char = '0;
    ld_cnt  = '0;
    ld_last = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        if (q_valid_i && can_load) begin
          pop_o = 1'b1;
          load  = 1'b1;
          unique case (q_op_i)
            sle_pkg::OP_PUT: begin
              wr_en   = 1'b1;
              ld_kind = sle_pkg::KIND_ECHO;
              ld_char = q_chr_i;
            end
            sle_pkg::OP_BELL: begin
              ld_kind = sle_pkg::KIND_BELL;
            end
            sle_pkg::OP_ERASE1: begin
              ld_kind = sle_pkg::KIND_ERASE;
              ld_cnt  = 6'd1;
            end
            sle_pkg::OP_KILL: begin
              ld_kind = sle_pkg::KIND_ERASE;
              ld_cnt  = q_cnt_i;
            end
            sle_pkg::OP_LINE: begin
              ld_kind = sle_pkg::KIND_NL;
              ld_last = 1'b0;
              idx_d   = q_num_i;
              state_d = S_SCAN;
            end
            default: begin
              ld_kind = sle_pkg::KIND_BELL;
            end
          endcase
        end
      end
      S_SCAN: begin
        // walk back over trailing spaces, one entry per read
        if (idx_q == '0) begin
          state_d = S_END;
        end else begin
          rd_en   = 1'b1;
          rd_addr = AW'(idx_q - 1'b1);
          state_d = S_SCHK;
        end
      end
      S_SCHK: begin
        if (rd_q == sle_pkg::SPACE7) begin
          idx_d   = idx_q - 1'b1;
          state_d = S_SCAN;
        end else begin
          len_d   = idx_q;
          pos_d   = '0;
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (pos_q == len_q) begin
          state_d = S_END;
        end else begin
          rd_en   = 1'b1;
          rd_addr = AW'(pos_q);
          state_d = S_ECHK;
        end
      end
      S_ECHK: begin
        if (can_load) begin
          load    = 1'b1;
          ld_kind = sle_pkg::KIND_CHAR;
          ld_char = rd_q;
          ld_last = 1'b0;
          pos_d   = pos_q + 1'b1;
          state_d = S_EMIT;
        end
      end
      S_END: begin
        if (can_load) begin
          load    = 1'b1;
          ld_kind = sle_pkg::KIND_END;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      pos_q   <= '0;
      len_q   <= '0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      pos_q   <= pos_d;
      len_q   <= len_d;
      if (can_load) begin
        out_v_q <= load;
      end
    end
  end

  // hold the result payload until the next beat is loaded
  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q <= ld_kind;
      char_q <= ld_char;
      cnt_q  <= ld_cnt;
      last_q <= ld_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_q[wr_addr] <= q_chr_i;
    end
    if (rd_en) begin
      rd_q <= store_q[rd_addr];
    end
  end

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> state_q == S_IDLE) else $error("command taken while busy");
  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT || state_q == S_ECHK) |-> pos_q <= len_q)
    else $error("line position past trimmed length");
  a_wr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> q_num_i < LW'(LINE_CAP)) else $error("store write beyond line capacity");

endmodule

// File: hdl/serial_line_editor.sv
// serial_line_editor: top level of the serial line editor.
// Uses sle_pkg, sle_rx_if, sle_res_if, sle_front, sle_queue, sle_back.
//
//   channel   dir  handshake          payload
//   rx_i      in   valid/ready        rx_byte[7:0]
//   res_o     out  valid/ready        kind[2:0] out_char[6:0] erase_count[5:0] last
//   cfg       in   cfg_we_i (no wait) cfg_wdata_i[5:0] = max_line_length
//
// A byte is taken while the two-entry command queue has room; the queue is
// registered, and an idle back pops the command and loads its echo, bell or erase
// result into the output register. A line end holds the back while it walks back
// over trimmed trailing spaces and then streams the delivered characters.
// Reset clears the line length, the queue and the output register and sets the
// length register to 62. A stalled output holds the back, and the front takes
// bytes until the queue fills.

module serial_line_editor #(
  parameter int BUFFER_DEPTH = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sle_rx_if.sink     rx_i,
  sle_res_if.source  res_o,
  input  logic       cfg_we_i,
  input  logic [5:0] cfg_wdata_i
);

  localparam int LW = $clog2(BUFFER_DEPTH);
  localparam int QW = 3 + 7 + LW + 6;

  logic          push;
  sle_pkg::op_e  f_op;
  logic [6:0]    f_chr;
  logic [LW-1:0] f_num;
  logic [5:0]    f_cnt;
  logic          q_full;
  logic          q_valid;
  logic          pop;
  logic [QW-1:0] q_data;

  sle_front #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx          (rx_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .op_o        (f_op),
    .chr_o       (f_chr),
    .num_o       (f_num),
    .cnt_o       (f_cnt)
  );

  sle_queue #(.W(QW)) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i ({f_op, f_chr, f_num, f_cnt}),
    .full_o      (q_full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .data_o      (q_data)
  );

  sle_back #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_op_i    (sle_pkg::op_e'(q_data[QW-1 -: 3])),
    .q_chr_i   (q_data[LW+6+7-1 -: 7]),
    .q_num_i   (q_data[LW+6-1 -: LW]),
    .q_cnt_i   (q_data[5:0]),
    .pop_o     (pop),
    .res       (res_o)
  );

endmodule
